// ----- rtl/pire_pkg.sv -----
// Shared types and constants of the rotated-ellipse point test.
package pire_pkg;

  // Sine and cosine are signed Q1.15; the table holds magnitudes only.
  localparam int SineMagW = 15;
  localparam int SineW = SineMagW + 1;
  localparam logic [SineMagW-1:0] SineMax = {SineMagW{1'b1}};

  // pi/2 in unsigned Q2.62, the seed of the table generator.
  localparam logic [63:0] PiHalfQ62 = 64'h6487_ED51_10B4_611A;

  // The squared Q1.15 factors on the left carry 2^30 more scale than the right.
  localparam int RhsShift = 2 * SineMagW;

  // Register stages between an accepted transaction and its result.
  localparam int PipeStages = 7;

  typedef enum logic [1:0] {
    QuadFirst  = 2'd0,
    QuadSecond = 2'd1,
    QuadThird  = 2'd2,
    QuadFourth = 2'd3
  } quadrant_e;

endpackage

// ----- rtl/pire_sine_rom.sv -----
// Quarter-wave sine table with registered reads and quadrant folding.
module pire_sine_rom #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [ANGLE_BITS-1:0]               angle_i,
  output logic signed [pire_pkg::SineW-1:0]   sin_o,
  output logic signed [pire_pkg::SineW-1:0]   cos_o
);

  localparam int KW = ANGLE_BITS - 2;
  localparam int AddrW = ANGLE_BITS - 1;
  localparam int Quarter = 2 ** KW;
  localparam int Depth = Quarter + 1;

  typedef logic [pire_pkg::SineMagW-1:0] rom_t [Depth];

  function automatic logic [63:0] mulq62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring division, only ever evaluated while the table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [pire_pkg::SineMagW-1:0] quarter_sine(logic [63:0] k);
    logic [63:0] lowmask;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    lowmask = (64'd1 << KW) - 64'd1;
    x = (pire_pkg::PiHalfQ62 >> KW) * k + (((pire_pkg::PiHalfQ62 & lowmask) * k) >> KW);
    sum = x;
    term = x;
    for (int n = 1; n < 40; n++) begin
      if (term == 64'd0) begin
        break;
      end
      term = div_u64(mulq62(mulq62(term, x), x), 64'(2 * n) * 64'(2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + (64'd1 << 46)) >> 47;
    if (r > 64'(pire_pkg::SineMax)) begin
      r = 64'(pire_pkg::SineMax);
    end
    return r[pire_pkg::SineMagW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < Depth; i++) begin
      t[i] = quarter_sine(64'(i));
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [KW-1:0]                   k;
  logic [AddrW-1:0]                addr_a;
  logic [AddrW-1:0]                addr_b;
  logic [pire_pkg::SineMagW-1:0]   sa_q;
  logic [pire_pkg::SineMagW-1:0]   sb_q;
  pire_pkg::quadrant_e             quad_q;
  logic signed [pire_pkg::SineW-1:0] sa_pos;
  logic signed [pire_pkg::SineW-1:0] sb_pos;

  assign k = angle_i[KW-1:0];
  assign addr_a = {1'b0, k};
  assign addr_b = AddrW'(Quarter) - {1'b0, k};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= SineRom[addr_a];
      sb_q   <= SineRom[addr_b];
      quad_q <= pire_pkg::quadrant_e'(angle_i[ANGLE_BITS-1:KW]);
    end
  end

  assign sa_pos = $signed({1'b0, sa_q});
  assign sb_pos = $signed({1'b0, sb_q});

  always_comb begin
    unique case (quad_q)
      pire_pkg::QuadFirst: begin
        sin_o = sa_pos;
        cos_o = sb_pos;
      end
      pire_pkg::QuadSecond: begin
        sin_o = sb_pos;
        cos_o = -sa_pos;
      end
      pire_pkg::QuadThird: begin
        sin_o = -sa_pos;
        cos_o = -sb_pos;
      end
      pire_pkg::QuadFourth: begin
        sin_o = -sb_pos;
        cos_o = sa_pos;
      end
      default: begin
        sin_o = sa_pos;
        cos_o = sb_pos;
      end
    endcase
  end

endmodule

// ----- rtl/point_in_rotated_ellipse.sv -----
// Pipelined strict point-in-rotated-ellipse test, one transaction per clock.
//
// The block takes one transaction per clock while in_ready_o is high and returns
// one result bit per transaction, in the order of acceptance. The
// offset of the point from the centre is rotated into the ellipse frame with
// Q1.15 sine and cosine read from a quarter-wave table of 2^(ANGLE_BITS-2)+1
// entries, and the comparison is exact, with no rounding of the rotated offset.
// Each of the seven register stages can hold a transaction, and empty stages
// close up behind a stalled result, so in_ready_o falls only when every stage
// is full and the output is not being taken. A point on the boundary is outside.
module point_in_rotated_ellipse #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0]        radius_x_i,
  input  logic [COORD_BITS-1:0]        radius_y_i,
  input  logic [ANGLE_BITS-1:0]        angle_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o
);

  localparam int C    = COORD_BITS;
  localparam int NS   = pire_pkg::PipeStages;
  localparam int DW   = C + 1;
  localparam int PW   = C + pire_pkg::SineW + 1;
  localparam int LW   = PW + 1;
  localparam int MW   = C + pire_pkg::SineW;
  localparam int RW   = 2 * C;
  localparam int R2W  = 4 * C;
  localparam int AW   = MW + C;
  localparam int LoW  = AW / 2;
  localparam int HiW  = AW - LoW;
  localparam int SqW  = 2 * AW;
  localparam int CmpW = SqW + 1;

  // Stage handshake.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS-1:0] vld_in;
  logic [NS:0]   en;

  assign en[NS] = out_ready_i;
  for (genvar g = 0; g < NS; g++) begin : g_en
    assign en[g] = !vld_q[g] || en[g+1];
  end

  assign vld_in = {vld_q[NS-2:0], in_valid_i};

  always_comb begin
    vld_d = vld_q;
    for (int i = 0; i < NS; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_in[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];

  // Stage 0: offsets and table read.
  logic signed [pire_pkg::SineW-1:0] sin_v;
  logic signed [pire_pkg::SineW-1:0] cos_v;
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [C-1:0] rx0_q, ry0_q;

  pire_sine_rom #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .angle_i(angle_i),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  assign dx_d = DW'(point_x_i) - DW'(center_x_i);
  assign dy_d = DW'(point_y_i) - DW'(center_y_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      rx0_q <= radius_x_i;
      ry0_q <= radius_y_i;
    end
  end

  // Stage 1: rotation products and radius product.
  logic signed [PW-1:0] cdx_d, sdy_d, cdy_d, sdx_d;
  logic signed [PW-1:0] cdx_q, sdy_q, cdy_q, sdx_q;
  logic [RW-1:0] rxy_d, rxy_q;
  logic [C-1:0]  rx1_q, ry1_q;

  assign cdx_d = cos_v * dx_q;
  assign sdy_d = sin_v * dy_q;
  assign cdy_d = cos_v * dy_q;
  assign sdx_d = sin_v * dx_q;
  assign rxy_d = rx0_q * ry0_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cdx_q <= cdx_d;
      sdy_q <= sdy_d;
      cdy_q <= cdy_d;
      sdx_q <= sdx_d;
      rxy_q <= rxy_d;
      rx1_q <= rx0_q;
      ry1_q <= ry0_q;
    end
  end

  // Stage 2: local coordinates as magnitudes, square of the radius product.
  logic signed [LW-1:0] lx_d, ly_d, lx_abs, ly_abs;
  logic [MW-1:0]  lx_mag_q, ly_mag_q;
  logic [R2W-1:0] rr2_d, rr2_q;
  logic [C-1:0]   rx2_q, ry2_q;

  assign lx_d   = LW'(cdx_q) + LW'(sdy_q);
  assign ly_d   = LW'(cdy_q) - LW'(sdx_q);
  assign lx_abs = lx_d[LW-1] ? -lx_d : lx_d;
  assign ly_abs = ly_d[LW-1] ? -ly_d : ly_d;
  assign rr2_d  = rxy_q * rxy_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lx_mag_q <= lx_abs[MW-1:0];
      ly_mag_q <= ly_abs[MW-1:0];
      rr2_q    <= rr2_d;
      rx2_q    <= rx1_q;
      ry2_q    <= ry1_q;
    end
  end

  // Stage 3: scale each local coordinate by the other radius.
  logic [AW-1:0]  ax_d, by_d, ax_q, by_q;
  logic [R2W-1:0] rr3_q;

  assign ax_d = lx_mag_q * ry2_q;
  assign by_d = ly_mag_q * rx2_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ax_q  <= ax_d;
      by_q  <= by_d;
      rr3_q <= rr2_q;
    end
  end

  // Stage 4: partial products of the two squares.
  logic [2*HiW-1:0]   ahh_d, bhh_d, ahh_q, bhh_q;
  logic [HiW+LoW-1:0] ahl_d, bhl_d, ahl_q, bhl_q;
  logic [2*LoW-1:0]   all_d, bll_d, all_q, bll_q;
  logic [R2W-1:0]     rr4_q;

  assign ahh_d = ax_q[AW-1:LoW] * ax_q[AW-1:LoW];
  assign ahl_d = ax_q[AW-1:LoW] * ax_q[LoW-1:0];
  assign all_d = ax_q[LoW-1:0] * ax_q[LoW-1:0];
  assign bhh_d = by_q[AW-1:LoW] * by_q[AW-1:LoW];
  assign bhl_d = by_q[AW-1:LoW] * by_q[LoW-1:0];
  assign bll_d = by_q[LoW-1:0] * by_q[LoW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ahh_q <= ahh_d;
      ahl_q <= ahl_d;
      all_q <= all_d;
      bhh_q <= bhh_d;
      bhl_q <= bhl_d;
      bll_q <= bll_d;
      rr4_q <= rr3_q;
    end
  end

  // Stage 5: assemble the squares.
  logic [SqW-1:0] asq_d, bsq_d, asq_q, bsq_q;
  logic [R2W-1:0] rr5_q;

  assign asq_d = (SqW'(ahh_q) << (2 * LoW)) + (SqW'(ahl_q) << (LoW + 1)) + SqW'(all_q);
  assign bsq_d = (SqW'(bhh_q) << (2 * LoW)) + (SqW'(bhl_q) << (LoW + 1)) + SqW'(bll_q);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      asq_q <= asq_d;
      bsq_q <= bsq_d;
      rr5_q <= rr4_q;
    end
  end

  // Stage 6: final sum and strict compare into the output register.
  logic [CmpW-1:0] lhs, rhs;
  logic            inside_d, inside_q;

  assign lhs      = CmpW'(asq_q) + CmpW'(bsq_q);
  assign rhs      = CmpW'(rr5_q) << pire_pkg::RhsShift;
  assign inside_d = lhs < rhs;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      inside_q <= inside_d;
    end
  end

  assign inside_res_o = inside_q;

endmodule

// ----- rtl/pire_checker.sv -----
// Port-level checks of the rotated-ellipse point test and their binding.
module pire_assertions (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic inside_res_i
);

  localparam int CntW = $clog2(pire_pkg::PipeStages + 1) + 1;

  logic            in_fire, out_fire;
  logic [CntW-1:0] pending_d, pending_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) begin
      pending_d = pending_q + CntW'(1);
    end else if (out_fire && !in_fire) begin
      pending_d = pending_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // The pipeline holds no more transactions than it has stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CntW'(pire_pkg::PipeStages))
    else $error("more transactions in flight than pipeline stages");

  // A result is only shown for a transaction that was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without an accepted transaction");

  // Input back-pressure only arises from a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while the output is free");

  // A waiting result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(inside_res_i))
    else $error("waiting result dropped or changed");

endmodule

bind point_in_rotated_ellipse pire_assertions u_pire_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .inside_res_i(inside_res_o)
);

// ----- bench/pire_checker.sv -----
// Checker for the rotated-ellipse point test: watches both channels, predicts and compares.
module pire_checker #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0]        radius_x_i,
  input  logic [COORD_BITS-1:0]        radius_y_i,
  input  logic [ANGLE_BITS-1:0]        angle_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         inside_res_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           inside_seen_o
);

  localparam int Quarter = 1 << (ANGLE_BITS - 2);

  typedef struct {
    int unsigned tag;
    logic        hit;
  } inside_exp_t;

  logic [pire_pkg::SineMagW-1:0] sine_mag [0:Quarter];
  inside_exp_t                   inside_fifo [$];
  int unsigned                   in_count;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Taylor series of sin at Q2.62, rounded to Q1.15 and clipped below 1.0.
  function automatic logic [pire_pkg::SineMagW-1:0] quarter_mag(input int unsigned k);
    logic [63:0] lowmask;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rounded;
    int          n;
    lowmask = (64'd1 << (ANGLE_BITS - 2)) - 64'd1;
    x = (pire_pkg::PiHalfQ62 >> (ANGLE_BITS - 2)) * 64'(k)
        + (((pire_pkg::PiHalfQ62 & lowmask) * 64'(k)) >> (ANGLE_BITS - 2));
    sum = x;
    term = x;
    for (n = 1; n < 40 && term != 64'd0; n++) begin
      term = mul_q62(mul_q62(term, x), x) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rounded = (sum + (64'd1 << 46)) >> 47;
    if (rounded > 64'(pire_pkg::SineMax)) begin
      rounded = 64'(pire_pkg::SineMax);
    end
    return rounded[pire_pkg::SineMagW-1:0];
  endfunction

  function automatic logic predict_inside(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] cx,
    input logic signed [COORD_BITS-1:0] cy,
    input logic [COORD_BITS-1:0]        rx,
    input logic [COORD_BITS-1:0]        ry,
    input logic [ANGLE_BITS-1:0]        ang
  );
    longint      dx;
    longint      dy;
    longint      sin_v;
    longint      cos_v;
    longint      sa;
    longint      sb;
    longint      lx;
    longint      ly;
    logic [63:0] mag_x;
    logic [63:0] mag_y;
    logic [191:0] term_x;
    logic [191:0] term_y;
    logic [191:0] rhs;
    pire_pkg::quadrant_e quad;
    int unsigned k;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    quad = pire_pkg::quadrant_e'(ang[ANGLE_BITS-1 -: 2]);
    k = ang[ANGLE_BITS-3:0];
    sa = longint'(sine_mag[k]);
    sb = longint'(sine_mag[Quarter - k]);
    case (quad)
      pire_pkg::QuadFirst: begin
        sin_v = sa;
        cos_v = sb;
      end
      pire_pkg::QuadSecond: begin
        sin_v = sb;
        cos_v = -sa;
      end
      pire_pkg::QuadThird: begin
        sin_v = -sa;
        cos_v = -sb;
      end
      default: begin
        sin_v = -sb;
        cos_v = sa;
      end
    endcase
    lx = cos_v * dx + sin_v * dy;
    ly = cos_v * dy - sin_v * dx;
    mag_x = (lx < 0) ? 64'(-lx) : 64'(lx);
    mag_y = (ly < 0) ? 64'(-ly) : 64'(ly);
    term_x = 192'(mag_x) * 192'(ry);
    term_x = term_x * term_x;
    term_y = 192'(mag_y) * 192'(rx);
    term_y = term_y * term_y;
    rhs = 192'(rx) * 192'(ry);
    rhs = (rhs * rhs) << pire_pkg::RhsShift;
    return (term_x + term_y) < rhs;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors_o < 100) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    checked_o = 0;
    inside_seen_o = 0;
    in_count = 0;
    for (int i = 0; i <= Quarter; i++) begin
      sine_mag[i] = quarter_mag(i);
    end
  end

  always @(posedge clk_i) begin
    inside_exp_t exp_item;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (inside_fifo.size() == 0) begin
          report_mismatch($sformatf("result inside_res=%0b with no transaction waiting",
                                    inside_res_i));
        end else begin
          exp_item = inside_fifo.pop_front();
          checked_o++;
          if (inside_res_i) begin
            inside_seen_o++;
          end
          if (inside_res_i !== exp_item.hit) begin
            report_mismatch($sformatf("transaction %0d: inside_res=%b, predicted %0b",
                                      exp_item.tag, inside_res_i, exp_item.hit));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        exp_item.tag = in_count;
        exp_item.hit = predict_inside(point_x_i, point_y_i, center_x_i, center_y_i,
                                      radius_x_i, radius_y_i, angle_i);
        inside_fifo.push_back(exp_item);
        in_count++;
      end
    end
    pending_o <= inside_fifo.size();
  end

  initial pending_o = 0;

endmodule

// ----- bench/tb_point_in_rotated_ellipse.sv -----
// Top of the rotated-ellipse point test bench: clock, reset, stimulus, watchdog and verdict.
module tb_point_in_rotated_ellipse;

  localparam int CoordW = 16;
  localparam int AngleW = 12;
  localparam int NumRandom = 1800;
  localparam int IdleLimit = 2000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [CoordW-1:0] point_x = '0;
  logic signed [CoordW-1:0] point_y = '0;
  logic signed [CoordW-1:0] center_x = '0;
  logic signed [CoordW-1:0] center_y = '0;
  logic [CoordW-1:0]        radius_x = 16'd1;
  logic [CoordW-1:0]        radius_y = 16'd1;
  logic [AngleW-1:0]        angle = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     inside_res;

  int  errors;
  int  pending;
  int  checked;
  int  inside_seen;
  int  sent = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  burst = 1'b0;

  always #5 clk_i = ~clk_i;

  point_in_rotated_ellipse #(
    .COORD_BITS(CoordW),
    .ANGLE_BITS(AngleW)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .radius_x_i  (radius_x),
    .radius_y_i  (radius_y),
    .angle_i     (angle),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .inside_res_o(inside_res)
  );

  pire_checker #(
    .COORD_BITS(CoordW),
    .ANGLE_BITS(AngleW)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .center_x_i   (center_x),
    .center_y_i   (center_y),
    .radius_x_i   (radius_x),
    .radius_y_i   (radius_y),
    .angle_i      (angle),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .inside_res_i (inside_res),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .inside_seen_o(inside_seen)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!burst && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= idle_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_point(input int px, input int py, input int cx, input int cy,
                            input int rx, input int ry, input int ang);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    point_x <= CoordW'(px);
    point_y <= CoordW'(py);
    center_x <= CoordW'(cx);
    center_y <= CoordW'(cy);
    radius_x <= CoordW'(rx);
    radius_y <= CoordW'(ry);
    angle <= AngleW'(ang);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  // Most points fall near an ellipse of random size so that both answers are common.
  task automatic send_random_point();
    int rx;
    int ry;
    int span;
    int cx;
    int cy;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 3) == 0) begin
      send_point(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)), cx, cy,
                 int'($urandom_range(1, 65535)), int'($urandom_range(1, 65535)),
                 int'($urandom_range(0, 4095)));
    end else begin
      rx = int'($urandom_range(1, 65535) >> $urandom_range(0, 15));
      ry = int'($urandom_range(1, 65535) >> $urandom_range(0, 15));
      if (rx == 0) begin
        rx = 1;
      end
      if (ry == 0) begin
        ry = 1;
      end
      span = ((rx > ry) ? rx : ry) + 2;
      send_point(cx + int'($urandom_range(0, 2 * span)) - span,
                 cy + int'($urandom_range(0, 2 * span)) - span,
                 cx, cy, rx, ry, int'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    int corner_angles[9] = '{0, 1, 512, 1023, 1024, 1025, 2048, 3072, 4095};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // The point at the centre of the smallest and of the largest ellipse.
    send_point(0, 0, 0, 0, 1, 1, 0);
    send_point(-32768, 32767, -32768, 32767, 65535, 65535, 4095);
    // Exactly on the boundary, where the saturated cosine is exact, and one step inside.
    send_point(16384, 0, -16384, 0, 32767, 1, 0);
    send_point(16383, 0, -16384, 0, 32767, 1, 0);
    send_point(16384, 0, -16384, 0, 32767, 1, 2048);
    send_point(0, 16384, 0, -16384, 1, 32767, 0);
    // Largest offsets in every direction across the quadrant seams.
    foreach (corner_angles[i]) begin
      send_point(32767, -32768, -32768, 32767, 65535, 65535, corner_angles[i]);
    end
    send_point(-32768, -32768, 32767, 32767, 65535, 1, 1024);
    send_point(0, 16, 0, 0, 1, 65535, 1024);
    send_point(16, 0, 0, 0, 1, 65535, 1024);
    send_point(1, 1, 0, 0, 1, 1, 512);
    send_point(32767, 32767, 32767, 32767, 65535, 1, 3072);

    for (int i = 0; i < NumRandom; i++) begin
      burst = ((i / 200) % 3) == 1;
      send_random_point();
    end
    burst = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (2 * pire_pkg::PipeStages) @(posedge clk_i);

    $display("Sent %0d transactions, checked %0d results, %0d of them inside.",
             sent, checked, inside_seen);
    $display("Covered extreme offsets and radii, exact boundaries, quadrant seams and stalls.");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
